@@ rtl/core/psu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_pkg
// shared types, constants and saturation helpers of the particle swarm block
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int PARTICLES  = 1024;
    localparam int ADDR_W     = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 24;
    localparam int GAIN_W     = 18;
    localparam int RAND_W     = 16;
    localparam int FIT_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W - FRAC_W;
    localparam int ACC_W      = 32;
    localparam int SUM_W      = 52;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ENTRY_W    = 3 * POS_W;

    localparam logic [GAIN_W-1:0]       INERTIA_RESET   = 18'd47828;
    localparam logic [GAIN_W-1:0]       COGNITIVE_RESET = 18'd98053;
    localparam logic [GAIN_W-1:0]       SOCIAL_RESET    = 18'd98053;
    localparam logic signed [POS_W-1:0] LOW_RESET       = -24'sd327680;
    localparam logic signed [POS_W-1:0] HIGH_RESET      = 24'sd327680;
    // f(0) = 6.0 in q32.16
    localparam logic signed [FIT_W-1:0] FIT_ZERO        = 48'sd393216;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SET    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INERTIA     = 3'd0,
        REG_COGNITIVE   = 3'd1,
        REG_SOCIAL      = 3'd2,
        REG_DOMAIN_LOW  = 3'd3,
        REG_DOMAIN_HIGH = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        STEP_IDLE,
        STEP_CAPTURE,
        STEP_K1,
        STEP_K2,
        STEP_WV,
        STEP_T2,
        STEP_T3,
        STEP_NV,
        STEP_XN,
        STEP_FX_IN,
        STEP_F1,
        STEP_F2,
        STEP_F3,
        STEP_F4,
        STEP_FX_XN,
        STEP_BEST,
        STEP_FIN
    } step_t;

    typedef struct packed {
        step_t step;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_range;
    } status_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, {(POS_W-1){1'b1}}}));
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return hi[POS_W-1:0];
        else if (v < lo)
            return lo[POS_W-1:0];
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [FIT_W-1:0] sat_fit(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, {(FIT_W-1){1'b1}}}));
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return hi[FIT_W-1:0];
        else if (v < lo)
            return lo[FIT_W-1:0];
        return v[FIT_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/psu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu channel interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface psu_item_if;
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [9:0]          particle_index;
    logic signed [23:0]  position_in;
    logic signed [23:0]  velocity_in;
    logic [15:0]         rand_one;
    logic [15:0]         rand_two;

    modport source (output valid, output operation, output particle_index,
                    output position_in, output velocity_in, output rand_one,
                    output rand_two, input ready);
    modport sink   (input valid, input operation, input particle_index,
                    input position_in, input velocity_in, input rand_one,
                    input rand_two, output ready);
endinterface

interface psu_result_if;
    logic                valid;
    logic                ready;
    logic [9:0]          particle_out;
    logic signed [23:0]  position_out;
    logic signed [23:0]  velocity_out;
    logic signed [23:0]  own_best_out;
    logic signed [23:0]  swarm_best_out;
    logic signed [47:0]  swarm_best_fitness;
    logic                best_changed;

    modport source (output valid, output particle_out, output position_out,
                    output velocity_out, output own_best_out, output swarm_best_out,
                    output swarm_best_fitness, output best_changed, input ready);
    modport sink   (input valid, input particle_out, input position_out,
                    input velocity_out, input own_best_out, input swarm_best_out,
                    input swarm_best_fitness, input best_changed, output ready);
endinterface

interface psu_cfg_if;
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [23:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/psu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_ctrl
// sequencer that steps the shared multiplier datapath through one item
// ----------------------------------------------------------------------------
module psu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  psu_pkg::status_t status,
    output psu_pkg::cmd_t    cmd
);
    import psu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_K1, S_K2, S_WV, S_T2, S_T3, S_NV, S_XN,
        S_FX_IN, S_F1, S_F2, S_F3, S_F4, S_FX_XN, S_BEST, S_FIN
    } state_t;

    state_t state_reg;
    logic   pass_reg;
    logic   out_valid_reg;
    logic   slot_free;

    assign slot_free  = !out_valid_reg || out_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        case (state_reg)
            S_IDLE:     cmd.step = item_valid ? STEP_CAPTURE : STEP_IDLE;
            S_DISPATCH: cmd.step = STEP_IDLE;
            S_K1:       cmd.step = STEP_K1;
            S_K2:       cmd.step = STEP_K2;
            S_WV:       cmd.step = STEP_WV;
            S_T2:       cmd.step = STEP_T2;
            S_T3:       cmd.step = STEP_T3;
            S_NV:       cmd.step = STEP_NV;
            S_XN:       cmd.step = STEP_XN;
            S_FX_IN:    cmd.step = STEP_FX_IN;
            S_F1:       cmd.step = STEP_F1;
            S_F2:       cmd.step = STEP_F2;
            S_F3:       cmd.step = STEP_F3;
            S_F4:       cmd.step = STEP_F4;
            S_FX_XN:    cmd.step = STEP_FX_XN;
            S_BEST:     cmd.step = STEP_BEST;
            S_FIN:      cmd.step = slot_free ? STEP_FIN : STEP_IDLE;
            default:    cmd.step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a commit in the same cycle refills the slot instead
            if (out_valid_reg && out_ready && cmd.step != STEP_FIN)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                        state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    if (status.op == OP_UPDATE && status.in_range)
                        state_reg <= S_K1;
                    else if (status.op == OP_SET || (status.op == OP_LOAD && status.in_range))
                        state_reg <= S_FX_IN;
                    else
                        state_reg <= S_FIN;
                end
                S_K1:    state_reg <= S_K2;
                S_K2:    state_reg <= S_WV;
                S_WV:    state_reg <= S_T2;
                S_T2:    state_reg <= S_T3;
                S_T3:    state_reg <= S_NV;
                S_NV:    state_reg <= S_XN;
                S_XN:    state_reg <= S_F1;
                S_FX_IN: state_reg <= S_F1;
                S_F1:    state_reg <= S_F2;
                S_F2:    state_reg <= S_F3;
                S_F3:    state_reg <= S_F4;
                S_F4:
                begin
                    // update runs the fitness twice: own best, then new position
                    if (status.op == OP_UPDATE && !pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_FX_XN;
                    end
                    else
                        state_reg <= S_BEST;
                end
                S_FX_XN: state_reg <= S_F1;
                S_BEST:  state_reg <= S_FIN;
                S_FIN:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pass_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_commit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == STEP_FIN |=> out_valid_reg)
        else $error("result slot not filled after commit");

    a_stall_holds_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !out_ready) |=> state_reg == S_FIN)
        else $error("commit while result slot occupied");

    a_second_pass_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FX_XN) |-> (pass_reg && status.op == OP_UPDATE))
        else $error("second fitness pass outside update");

endmodule
`default_nettype wire

@@ rtl/core/psu_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psu_datapath
// particle memory, registers, shared multiplier and result register
// ----------------------------------------------------------------------------
module psu_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  psu_pkg::cmd_t                     cmd,
    output psu_pkg::status_t                  status,
    input  logic [1:0]                        operation,
    input  logic [psu_pkg::IDX_W-1:0]         particle_index,
    input  logic signed [psu_pkg::POS_W-1:0]  position_in,
    input  logic signed [psu_pkg::POS_W-1:0]  velocity_in,
    input  logic [psu_pkg::RAND_W-1:0]        rand_one,
    input  logic [psu_pkg::RAND_W-1:0]        rand_two,
    input  logic                              cfg_write,
    input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [psu_pkg::IDX_W-1:0]         particle_out,
    output logic signed [psu_pkg::POS_W-1:0]  position_out,
    output logic signed [psu_pkg::POS_W-1:0]  velocity_out,
    output logic signed [psu_pkg::POS_W-1:0]  own_best_out,
    output logic signed [psu_pkg::POS_W-1:0]  swarm_best_out,
    output logic signed [psu_pkg::FIT_W-1:0]  swarm_best_fitness,
    output logic                              best_changed
);
    import psu_pkg::*;

    // configuration
    logic [GAIN_W-1:0]        w_reg, cg_reg, sg_reg;
    logic signed [POS_W-1:0]  lo_reg, hi_reg;
    // swarm best
    logic signed [POS_W-1:0]  sb_reg;
    logic signed [FIT_W-1:0]  sv_reg;
    // captured item
    op_t                      op_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic signed [POS_W-1:0]  pin_reg, vin_reg;
    logic [RAND_W-1:0]        r1_reg, r2_reg;
    // particle memory
    logic [ENTRY_W-1:0]       mem [PARTICLES];
    logic [ENTRY_W-1:0]       rd_reg;
    // working registers
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  k1_reg, k2_reg, acc_reg, s_reg;
    logic signed [PROD_W-1:0] c_reg;
    logic signed [POS_W-1:0]  nv_reg, xn_reg, fx_reg, pb_reg;
    logic signed [FIT_W-1:0]  f_reg, fp_reg, fb_reg;

    logic [ADDR_W+IDX_W-1:0]  idx_ext;
    logic signed [POS_W-1:0]  cur_x, cur_v, cur_p;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] product;
    logic signed [SUM_W-1:0]  fit_sum;
    logic signed [POS_W-1:0]  clamp_x, clamp_v;
    logic                     better, in_range, stores;

    assign idx_ext = (ADDR_W+IDX_W)'(particle_index);
    assign cur_x   = rd_reg[3*POS_W-1:2*POS_W];
    assign cur_v   = rd_reg[2*POS_W-1:POS_W];
    assign cur_p   = rd_reg[POS_W-1:0];
    assign in_range = (32'(idx_reg) < 32'(PARTICLES));
    assign status.op       = op_reg;
    assign status.in_range = in_range;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (cmd.step)
            STEP_K1:
            begin
                mul_a = MUL_W'(r1_reg);
                mul_b = MUL_W'(cg_reg);
            end
            STEP_K2:
            begin
                mul_a = MUL_W'(r2_reg);
                mul_b = MUL_W'(sg_reg);
            end
            STEP_WV:
            begin
                mul_a = MUL_W'(w_reg);
                mul_b = MUL_W'(cur_v);
            end
            STEP_T2:
            begin
                mul_a = k1_reg;
                mul_b = MUL_W'(cur_p) - MUL_W'(cur_x);
            end
            STEP_T3:
            begin
                mul_a = k2_reg;
                mul_b = MUL_W'(sb_reg) - MUL_W'(cur_x);
            end
            STEP_F1:
            begin
                mul_a = MUL_W'(fx_reg);
                mul_b = MUL_W'(fx_reg);
            end
            STEP_F2:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(fx_reg);
            end
            STEP_F3:
            begin
                mul_a = s_reg;
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // q + 2c - 12s - 2x + 6
    assign fit_sum = SUM_W'(prod_reg) + (SUM_W'(c_reg) <<< 1) - (SUM_W'(s_reg) * SUM_W'(12))
                   - (SUM_W'(fx_reg) <<< 1) + SUM_W'(FIT_ZERO);

    assign better = (sv_reg > fb_reg);
    assign stores = in_range && (op_reg == OP_LOAD || op_reg == OP_UPDATE);

    // clamp high first, then low, so crossed bounds end on the low bound
    always_comb
    begin
        clamp_x = xn_reg;
        clamp_v = nv_reg;
        if (clamp_x > hi_reg)
        begin
            clamp_x = hi_reg;
            clamp_v = '0;
        end
        if (clamp_x < lo_reg)
        begin
            clamp_x = lo_reg;
            clamp_v = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= INERTIA_RESET;
            cg_reg <= COGNITIVE_RESET;
            sg_reg <= SOCIAL_RESET;
            lo_reg <= LOW_RESET;
            hi_reg <= HIGH_RESET;
            sb_reg <= '0;
            sv_reg <= FIT_ZERO;
            op_reg <= OP_NONE;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_INERTIA:     w_reg  <= cfg_data[GAIN_W-1:0];
                    REG_COGNITIVE:   cg_reg <= cfg_data[GAIN_W-1:0];
                    REG_SOCIAL:      sg_reg <= cfg_data[GAIN_W-1:0];
                    REG_DOMAIN_LOW:  lo_reg <= cfg_data[POS_W-1:0];
                    REG_DOMAIN_HIGH: hi_reg <= cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.step == STEP_CAPTURE)
                op_reg <= op_t'(operation);
            if (cmd.step == STEP_FIN)
            begin
                if (op_reg == OP_SET)
                begin
                    sb_reg <= pb_reg;
                    sv_reg <= fb_reg;
                end
                else if (stores && better)
                begin
                    sb_reg <= pb_reg;
                    sv_reg <= fb_reg;
                end
            end
        end
    end

    // memory port: one write, one registered read
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[addr_reg];
        if (cmd.step == STEP_FIN && stores)
        begin
            if (op_reg == OP_LOAD)
                mem[addr_reg] <= {pin_reg, vin_reg, pin_reg};
            else
                mem[addr_reg] <= {clamp_x, clamp_v, pb_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(product >>> FRAC_W);
        case (cmd.step)
            STEP_CAPTURE:
            begin
                idx_reg  <= particle_index;
                addr_reg <= idx_ext[ADDR_W-1:0];
                pin_reg  <= position_in;
                vin_reg  <= velocity_in;
                r1_reg   <= rand_one;
                r2_reg   <= rand_two;
            end
            STEP_K2:    k1_reg  <= prod_reg[ACC_W-1:0];
            STEP_WV:    k2_reg  <= prod_reg[ACC_W-1:0];
            STEP_T2:    acc_reg <= prod_reg[ACC_W-1:0];
            STEP_T3:    acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            STEP_NV:    nv_reg  <= sat_pos(acc_reg + prod_reg[ACC_W-1:0]);
            STEP_XN:
            begin
                xn_reg <= sat_pos(ACC_W'(cur_x) + ACC_W'(nv_reg));
                fx_reg <= cur_p;
            end
            STEP_FX_IN: fx_reg <= pin_reg;
            STEP_F2:    s_reg  <= prod_reg[ACC_W-1:0];
            STEP_F3:    c_reg  <= prod_reg;
            STEP_F4:    f_reg  <= sat_fit(fit_sum);
            STEP_FX_XN:
            begin
                fp_reg <= f_reg;
                fx_reg <= xn_reg;
            end
            STEP_BEST:
            begin
                if (op_reg == OP_UPDATE)
                begin
                    if (fp_reg > f_reg)
                    begin
                        pb_reg <= xn_reg;
                        fb_reg <= f_reg;
                    end
                    else
                    begin
                        pb_reg <= cur_p;
                        fb_reg <= fp_reg;
                    end
                end
                else
                begin
                    pb_reg <= pin_reg;
                    fb_reg <= f_reg;
                end
            end
            STEP_FIN:
            begin
                particle_out       <= (op_reg == OP_LOAD || op_reg == OP_UPDATE) ? idx_reg : '0;
                position_out       <= '0;
                velocity_out       <= '0;
                own_best_out       <= '0;
                swarm_best_out     <= sb_reg;
                swarm_best_fitness <= sv_reg;
                best_changed       <= 1'b0;
                if (op_reg == OP_SET)
                begin
                    swarm_best_out     <= pb_reg;
                    swarm_best_fitness <= fb_reg;
                    best_changed       <= 1'b1;
                end
                else if (stores)
                begin
                    position_out <= (op_reg == OP_LOAD) ? pin_reg : clamp_x;
                    velocity_out <= (op_reg == OP_LOAD) ? vin_reg : clamp_v;
                    own_best_out <= pb_reg;
                    best_changed <= better;
                    if (better)
                    begin
                        swarm_best_out     <= pb_reg;
                        swarm_best_fitness <= fb_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    a_best_never_worsens: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_FIN && op_reg != OP_SET) |=> !(sv_reg > $past(sv_reg)))
        else $error("swarm best fitness grew outside a set");

    a_clamp_in_domain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_FIN && op_reg == OP_UPDATE && in_range && !(lo_reg > hi_reg))
        |=> (position_out >= $past(lo_reg) && position_out <= $past(hi_reg)))
        else $error("updated position outside domain");

    a_set_reports_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_FIN && op_reg == OP_SET) |=> (best_changed && swarm_best_out == sb_reg))
        else $error("set global not reported");

endmodule
`default_nettype wire

@@ rtl/core/particle_swarm_update_1d_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_swarm_update_1d_top
// one-dimensional particle swarm step engine for a fixed quartic objective
// ----------------------------------------------------------------------------
// usage
//   item   : valid/ready channel; operation load, set global best or update
//   result : valid/ready channel; exactly one result per item transfer
//   cfg    : valid/ready register write channel, always ready; write only
//            while no item is in flight and no result is pending
// work, from the item transfer to result valid
//   update             : eleven products through one shared
//                        32x32 multiplier in series plus the final sums
//   load, set global   : one fitness evaluation (three products)
//   unused op          : no products, straight to the result
//   one item at a time; the next item can be taken in the cycle after the
//   result register is loaded
// reset
//   registers return to their defaults, global best is zero with fitness 6.0;
//   particle memory is not cleared, a particle must be loaded before update
// stall
//   a result waits in the output register while a new item is worked on;
//   a finished item holds in its commit step until the register frees up
// ----------------------------------------------------------------------------
module particle_swarm_update_1d_top (
    input  logic         clk,
    input  logic         rst_n,
    psu_item_if.sink     item,
    psu_result_if.source result,
    psu_cfg_if.sink      cfg
);
    import psu_pkg::*;

    cmd_t    cmd;
    status_t status;

    // register writes go straight into the registers, never back-pressured
    assign cfg.ready = 1'b1;

    // sequencer: handshakes and step order
    psu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: particle memory, multiplier, bests and result register
    psu_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .operation          (item.operation),
        .particle_index     (item.particle_index),
        .position_in        (item.position_in),
        .velocity_in        (item.velocity_in),
        .rand_one           (item.rand_one),
        .rand_two           (item.rand_two),
        .cfg_write          (cfg.valid),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .particle_out       (result.particle_out),
        .position_out       (result.position_out),
        .velocity_out       (result.velocity_out),
        .own_best_out       (result.own_best_out),
        .swarm_best_out     (result.swarm_best_out),
        .swarm_best_fitness (result.swarm_best_fitness),
        .best_changed       (result.best_changed)
    );

endmodule
`default_nettype wire

@@ tb/tb_psu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_psu_checker
// watches item, result and register transfers, keeps its own copy of the
// swarm state, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module tb_psu_checker (
    input  logic         clk,
    input  logic         rst_n,
    psu_item_if.sink     item,
    psu_result_if.sink   result,
    psu_cfg_if.sink      cfg,
    output int           fail_count,
    output int           pending
);
    import psu_pkg::*;

    typedef struct {
        logic [9:0]          pidx;
        logic signed [23:0]  pos;
        logic signed [23:0]  vel;
        logic signed [23:0]  own;
        logic signed [23:0]  best;
        logic signed [47:0]  fit;
        logic                changed;
    } swarm_result_t;

    swarm_result_t expected_q[$];

    longint w_gain, c_gain, s_gain, lo_bound, hi_bound;
    longint pos_mem[PARTICLES];
    longint vel_mem[PARTICLES];
    longint own_mem[PARTICLES];
    longint best_pos, best_fit;

    function automatic longint floor_q16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // quartic x^4 + 2x^3 - 12x^2 - 2x + 6 in q32.16
    function automatic longint quartic(longint x);
        longint sq;
        longint cu;
        longint qu;
        sq = floor_q16(x * x);
        cu = floor_q16(sq * x);
        qu = floor_q16(sq * sq);
        return clip(qu + 2 * cu - 12 * sq - 2 * x + (longint'(6) << 16), 48);
    endfunction

    function automatic logic try_swarm_best(longint cand);
        longint fc;
        fc = quartic(cand);
        if (best_fit > fc)
        begin
            best_pos = cand;
            best_fit = fc;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic swarm_result_t predict_step(op_t op, int idx, longint pin,
                                                   longint vin, longint r1, longint r2);
        swarm_result_t r;
        longint x, v, p, k1, k2, nv;
        r.pidx = '0; r.pos = '0; r.vel = '0; r.own = '0; r.changed = 1'b0;
        if (op == OP_SET)
        begin
            best_pos = pin;
            best_fit = quartic(pin);
            r.changed = 1'b1;
        end
        else if (op == OP_LOAD || op == OP_UPDATE)
        begin
            r.pidx = idx[9:0];
            if (op == OP_LOAD)
            begin
                x = pin; nv = vin; p = pin;
                r.changed = try_swarm_best(p);
            end
            else
            begin
                x = pos_mem[idx]; v = vel_mem[idx]; p = own_mem[idx];
                k1 = floor_q16(r1 * c_gain);
                k2 = floor_q16(r2 * s_gain);
                nv = floor_q16(w_gain * v) + floor_q16(k1 * (p - x))
                   + floor_q16(k2 * (best_pos - x));
                nv = clip(nv, 24);
                x = clip(x + nv, 24);
                if (quartic(p) > quartic(x))
                    p = x;
                r.changed = try_swarm_best(p);
                if (x > hi_bound)
                begin
                    x = hi_bound; nv = 0;
                end
                if (x < lo_bound)
                begin
                    x = lo_bound; nv = 0;
                end
            end
            pos_mem[idx] = x; vel_mem[idx] = nv; own_mem[idx] = p;
            r.pos = x[23:0]; r.vel = nv[23:0]; r.own = p[23:0];
        end
        r.best = best_pos[23:0];
        r.fit = best_fit[47:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        swarm_result_t exp_r;
        if (!rst_n)
        begin
            w_gain = INERTIA_RESET; c_gain = COGNITIVE_RESET; s_gain = SOCIAL_RESET;
            lo_bound = LOW_RESET; hi_bound = HIGH_RESET;
            best_pos = 0; best_fit = quartic(0);
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_INERTIA:     w_gain = cfg.data[17:0];
                    REG_COGNITIVE:   c_gain = cfg.data[17:0];
                    REG_SOCIAL:      s_gain = cfg.data[17:0];
                    REG_DOMAIN_LOW:  lo_bound = longint'(signed'(cfg.data));
                    REG_DOMAIN_HIGH: hi_bound = longint'(signed'(cfg.data));
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", result.particle_out, -1);
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.particle_out !== exp_r.pidx)
                        report_mismatch("particle_out", result.particle_out, exp_r.pidx);
                    if (result.position_out !== exp_r.pos)
                        report_mismatch("position_out", result.position_out, exp_r.pos);
                    if (result.velocity_out !== exp_r.vel)
                        report_mismatch("velocity_out", result.velocity_out, exp_r.vel);
                    if (result.own_best_out !== exp_r.own)
                        report_mismatch("own_best_out", result.own_best_out, exp_r.own);
                    if (result.swarm_best_out !== exp_r.best)
                        report_mismatch("swarm_best_out", result.swarm_best_out,
                                        exp_r.best);
                    if (result.swarm_best_fitness !== exp_r.fit)
                        report_mismatch("swarm_best_fitness", result.swarm_best_fitness,
                                        exp_r.fit);
                    if (result.best_changed !== exp_r.changed)
                        report_mismatch("best_changed", result.best_changed,
                                        exp_r.changed);
                end
            end
            if (item.valid && item.ready)
                expected_q.push_back(predict_step(op_t'(item.operation),
                    int'(item.particle_index), longint'(item.position_in),
                    longint'(item.velocity_in), longint'(item.rand_one),
                    longint'(item.rand_two)));
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the particle swarm step engine: directed corner
// items and register extremes, then random well-formed swarms under several idling phases
// ----------------------------------------------------------------------------
module tb_top;
    import psu_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;

    // stall control for the result side
    int   stall_pct = 0;
    logic hold_off = 1'b0;

    // loaded particles; updates only touch these
    bit   loaded[PARTICLES];
    int   loaded_list[$];

    psu_item_if   item_ch();
    psu_result_if result_ch();
    psu_cfg_if    cfg_ch();

    always #4 clk = ~clk;

    particle_swarm_update_1d_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    tb_psu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch.sink),
        .result     (result_ch.sink),
        .cfg        (cfg_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.operation = OP_LOAD;
        item_ch.particle_index = '0;
        item_ch.position_in = '0;
        item_ch.velocity_in = '0;
        item_ch.rand_one = '0;
        item_ch.rand_two = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_INERTIA;
        cfg_ch.data = '0;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
        result_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // one item transfer; sender idles at random before offering
    task automatic send_item(op_t op, int idx, int pos, int vel, int r1, int r2,
                             int idle_pct);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        item_ch.valid = 1'b1;
        item_ch.operation = op;
        item_ch.particle_index = idx[9:0];
        item_ch.position_in = pos[23:0];
        item_ch.velocity_in = vel[23:0];
        item_ch.rand_one = r1[15:0];
        item_ch.rand_two = r2[15:0];
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        item_ch.valid = 1'b0;
        if (op == OP_LOAD && idx < PARTICLES && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    // let every result drain, then the longest item latency
    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t which, int value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = which;
        cfg_ch.data = value[23:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic int rand_pos();
        case ($urandom_range(9))
            0: return $urandom_range(16777215) - 8388608;
            1: return $urandom_range(1) ? 8388607 : -8388608;
            default: return int'($urandom_range(786432)) - 393216;
        endcase
    endfunction

    // a swarm burst: a random mix of loads, updates, set-global and unused ops with random draws
    task automatic swarm_burst(int count, int idle_pct);
        int idx;
        int n;
        for (n = 0; n < count; n++)
        begin
            idx = $urandom_range(PARTICLES - 1) % 64 + ($urandom_range(15) == 0 ?
                  $urandom_range(PARTICLES - 1) : 0);
            idx = idx % PARTICLES;
            case ($urandom_range(19))
                0: send_item(OP_SET, $urandom_range(1023), rand_pos(), rand_pos(),
                             $urandom_range(65535), $urandom_range(65535), idle_pct);
                1: send_item(OP_NONE, $urandom_range(1023), rand_pos(), rand_pos(),
                             $urandom_range(65535), $urandom_range(65535), idle_pct);
                2, 3, 4:
                    send_item(OP_LOAD, idx, rand_pos(), rand_pos() >>> $urandom_range(8),
                              $urandom_range(65535), $urandom_range(65535), idle_pct);
                default:
                    if (loaded_list.size() == 0)
                        send_item(OP_LOAD, idx, rand_pos(), rand_pos(), 0, 0, idle_pct);
                    else
                        send_item(OP_UPDATE,
                                  loaded_list[$urandom_range(loaded_list.size() - 1)],
                                  rand_pos(), rand_pos(), $urandom_range(65535),
                                  $urandom_range(65535), idle_pct);
            endcase
        end
    endtask

    initial
    begin
        int phase;
        int cnt;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes of every field, every operation, unused op
        send_item(OP_NONE, 1023, 8388607, -8388608, 65535, 65535, 0);
        send_item(OP_LOAD, 0, 0, 0, 0, 0, 0);
        send_item(OP_LOAD, 1023, 8388607, 8388607, 65535, 65535, 0);
        send_item(OP_LOAD, 1, -8388608, -8388608, 0, 0, 0);
        send_item(OP_LOAD, 2, 65536, 32768, 0, 0, 0);
        send_item(OP_UPDATE, 1023, 0, 0, 65535, 65535, 0);
        send_item(OP_UPDATE, 1, 0, 0, 65535, 0, 0);
        send_item(OP_UPDATE, 2, 0, 0, 0, 65535, 0);
        send_item(OP_UPDATE, 0, 0, 0, 0, 0, 0);
        send_item(OP_SET, 0, 8388607, 0, 0, 0, 0);
        send_item(OP_UPDATE, 2, 0, 0, 32768, 32768, 0);
        send_item(OP_SET, 1023, -8388608, 0, 0, 0, 0);
        send_item(OP_SET, 5, 98304, 0, 0, 0, 0);
        send_item(OP_UPDATE, 1, 0, 0, 65535, 65535, 0);
        send_item(OP_LOAD, 3, -655360, 0, 0, 0, 0);
        wait_idle();

        // register extremes, including crossed bounds where the low one wins
        write_reg(REG_INERTIA, 262143);
        write_reg(REG_COGNITIVE, 262143);
        write_reg(REG_SOCIAL, 262143);
        write_reg(REG_DOMAIN_LOW, 8388607);
        write_reg(REG_DOMAIN_HIGH, -8388608);
        send_item(OP_UPDATE, 0, 0, 0, 65535, 65535, 0);
        send_item(OP_UPDATE, 1023, 0, 0, 65535, 65535, 0);
        send_item(OP_UPDATE, 3, 0, 0, 1, 1, 0);
        wait_idle();
        write_reg(REG_INERTIA, 0);
        write_reg(REG_COGNITIVE, 0);
        write_reg(REG_SOCIAL, 0);
        write_reg(REG_DOMAIN_LOW, -8388608);
        write_reg(REG_DOMAIN_HIGH, 8388607);
        send_item(OP_UPDATE, 2, 0, 0, 65535, 65535, 0);
        send_item(OP_UPDATE, 1, 0, 0, 65535, 65535, 0);
        wait_idle();

        // random phases, each under its own register setting
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin stall_pct = 0; cnt = 0; end
                1: begin stall_pct = 0; cnt = 72; end
                2: begin stall_pct = 72; cnt = 0; end
                default: begin stall_pct = 35; cnt = 35; end
            endcase
            if (phase == 0)
            begin
                write_reg(REG_INERTIA, INERTIA_RESET);
                write_reg(REG_COGNITIVE, COGNITIVE_RESET);
                write_reg(REG_SOCIAL, SOCIAL_RESET);
                write_reg(REG_DOMAIN_LOW, LOW_RESET);
                write_reg(REG_DOMAIN_HIGH, HIGH_RESET);
            end
            else
            begin
                write_reg(REG_INERTIA, $urandom_range(262143));
                write_reg(REG_COGNITIVE, $urandom_range(262143));
                write_reg(REG_SOCIAL, $urandom_range(262143));
                write_reg(REG_DOMAIN_LOW, rand_pos());
                write_reg(REG_DOMAIN_HIGH, rand_pos());
            end
            swarm_burst(200, cnt);
            if (phase == 2)
            begin
                // long receiver hold-off while items keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    swarm_burst(12, 0);
                join
            end
            wait_idle();
        end

        wait_idle();
        if (fail_count == 0)
            $display("particle_swarm_update_1d_top regression: pass");
        else
            $display("particle_swarm_update_1d_top regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("particle_swarm_update_1d_top regression: fail");
        $finish;
    end

endmodule

@@ particle_swarm_update_1d_top.f @@
rtl/core/psu_pkg.sv
rtl/core/psu_if.sv
rtl/core/psu_ctrl.sv
rtl/core/psu_datapath.sv
rtl/core/particle_swarm_update_1d_top.sv
tb/tb_psu_checker.sv
tb/tb_top.sv
